// ===== src/sim_pkg.sv =====
`default_nettype none

package sim_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_DIM_DEF    = 4096;
  localparam int SCAN_COUNT_DEF = 6;

  // Field widths
  localparam int PIX_W = 32;
  localparam int CFG_W = 13;
  localparam int TOL_W = 9;
  localparam int CNT_W = 20;
  localparam int IDX_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_CHANNEL_TOL  = 2'd2;

  // Register reset values
  localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 13'd64;
  localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 13'd64;
  localparam logic [TOL_W-1:0] RST_CHANNEL_TOL  = 9'd32;

  // Match rule: 20 * count >= 19 * sampled, i.e. at least 95 percent
  localparam int MATCH_NUM   = 19;
  localparam int MATCH_DEN   = 20;
  localparam int SPECIAL_DIM = 27;

  // Transparent white; paired with transparent black it counts as a full match
  localparam logic [PIX_W-1:0] CLEAR_WHITE = 32'h00FF_FFFF;

  // Per-pair compare flags
  typedef struct packed {
    logic equal;
    logic red;
    logic green;
    logic blue;
    logic alpha;
  } pix_cmp_t;

endpackage

`default_nettype wire

// ===== src/sim_pix_cmp.sv =====
`default_nettype none

module sim_pix_cmp (
  input  wire logic [sim_pkg::PIX_W-1:0] src_pixel,
  input  wire logic [sim_pkg::PIX_W-1:0] dst_pixel,
  input  wire logic [sim_pkg::TOL_W-1:0] tolerance,
  output sim_pkg::pix_cmp_t              flags
);

  logic       special;
  logic [7:0] diff_r8;
  logic [7:0] diff_g8;
  logic [7:0] diff_b8;

  // Absolute channel difference
  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    if (a > b) begin
      d = a - b;
    end else begin
      d = b - a;
    end
    return d;
  endfunction

  always_comb begin
    special = (src_pixel == '0 && dst_pixel == sim_pkg::CLEAR_WHITE) ||
              (dst_pixel == '0 && src_pixel == sim_pkg::CLEAR_WHITE);
    diff_r8 = abs_diff(src_pixel[23:16], dst_pixel[23:16]);
    diff_g8 = abs_diff(src_pixel[15:8], dst_pixel[15:8]);
    diff_b8 = abs_diff(src_pixel[7:0], dst_pixel[7:0]);

    // Close RGB within tolerance, alpha exact
    flags.equal = (src_pixel == dst_pixel);
    flags.red   = special || ({1'b0, diff_r8} < tolerance);
    flags.green = special || ({1'b0, diff_g8} < tolerance);
    flags.blue  = special || ({1'b0, diff_b8} < tolerance);
    flags.alpha = special || (src_pixel[31:24] == dst_pixel[31:24]);
  end

endmodule

`default_nettype wire

// ===== src/sim_off_div.sv =====
`default_nettype none

// Scan spacing dim / (2 * SCAN_COUNT) by reciprocal multiply, registered.
// The ceiling reciprocal with LOG_D extra bits gives the exact quotient for
// every dim below 2**DIM_W.
module sim_off_div #(
  parameter int SCAN_COUNT = sim_pkg::SCAN_COUNT_DEF,
  parameter int DIM_W      = 13,
  parameter int OFF_W      = 9
) (
  input  wire logic             clk,
  input  wire logic [DIM_W-1:0] dim,
  output logic      [OFF_W-1:0] off
);

  localparam int DIV     = 2 * SCAN_COUNT;
  localparam int LOG_D   = $clog2(DIV);
  localparam int SH      = DIM_W + LOG_D;
  localparam int RECIP   = ((1 << SH) + DIV - 1) / DIV;
  localparam int RECIP_W = SH - LOG_D + 2;
  localparam int PROD_W  = DIM_W + RECIP_W;

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] quot;
  logic [OFF_W-1:0]  off_r;
  logic [OFF_W-1:0]  off_nxt;

  always_comb begin
    prod    = PROD_W'(dim) * PROD_W'(RECIP);
    quot    = prod >> SH;
    off_nxt = quot[OFF_W-1:0];
  end

  // Register the spacing; it follows the dimension register in the next cycle
  always_ff @(posedge clk) begin
    off_r <= off_nxt;
  end

  assign off = off_r;

endmodule

`default_nettype wire

// ===== src/scanline_image_match.sv =====
// Compares two equal-size ARGB images streamed as raster-order pixel pairs
// (in_tdata: source pixel in bits 31:0, second pixel in 63:32), row by row,
// left to right. One pair is taken every clock cycle unless stalled; a pair
// passes an input register and then one state-update stage, which for the
// last pair of a frame also loads the out_tdata result register, and the
// input stalls only while a finished result waits on out_tready. The
// result is one transfer per frame: match verdict, bitwise identity and the
// per-channel match counts over the scan-line samples (rows and columns every
// dimension/(2*SCAN_COUNT), an intersection counted twice). Dimensions are
// clamped to 1..MAX_DIM. The scan spacing is recomputed in the cycle after a
// write to image_width or image_height.
`default_nettype none

module scanline_image_match #(
  parameter int MAX_DIM    = sim_pkg::MAX_DIM_DEF,
  parameter int SCAN_COUNT = sim_pkg::SCAN_COUNT_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // configuration
  input  wire logic                      cfg_we,
  input  wire logic [sim_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [sim_pkg::CFG_W-1:0] cfg_wdata,
  // pixel pairs
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [63:0]               in_tdata,   // src_pixel[31:0], dst_pixel[63:32]
  // frame results
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  // images_match[0], identical[1], red_matches[21:2], green_matches[41:22],
  // blue_matches[61:42], alpha_matches[81:62], sampled_count[101:82], zero pad
  output logic [103:0]                   out_tdata
);

  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int POS_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int OFF_MAX = MAX_DIM / (2 * SCAN_COUNT);
  localparam int OFF_W   = (OFF_MAX > 0) ? $clog2(OFF_MAX + 1) : 1;
  localparam int CNT_W   = sim_pkg::CNT_W;
  localparam int RAT_W   = CNT_W + 5;

  // Configuration registers
  logic [sim_pkg::CFG_W-1:0] width_cfg_r;
  logic [sim_pkg::CFG_W-1:0] height_cfg_r;
  logic [sim_pkg::TOL_W-1:0] tol_cfg_r;

  // Effective dimensions and spacing
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic [OFF_W-1:0] coff;
  logic [OFF_W-1:0] roff;

  // Input stage
  logic                      pipe_vld_r;
  logic [sim_pkg::PIX_W-1:0] pipe_src_r;
  logic [sim_pkg::PIX_W-1:0] pipe_dst_r;
  logic                      in_xfer;
  logic                      adv;

  // Frame state
  logic [POS_W-1:0] col_pos_r,   col_pos_nxt;
  logic [POS_W-1:0] row_pos_r,   row_pos_nxt;
  logic [OFF_W-1:0] col_phase_r, col_phase_nxt;
  logic [OFF_W-1:0] row_phase_r, row_phase_nxt;
  logic [CNT_W-1:0] red_cnt_r,   red_cnt_nxt;
  logic [CNT_W-1:0] green_cnt_r, green_cnt_nxt;
  logic [CNT_W-1:0] blue_cnt_r,  blue_cnt_nxt;
  logic [CNT_W-1:0] alpha_cnt_r, alpha_cnt_nxt;
  logic [CNT_W-1:0] visit_cnt_r, visit_cnt_nxt;
  logic             all_equal_r, all_equal_nxt;

  // Per-pair work
  sim_pkg::pix_cmp_t flags;
  logic [1:0]        visits;
  logic [CNT_W-1:0]  red_upd, green_upd, blue_upd, alpha_upd, visit_upd;
  logic              eq_upd;
  logic              row_end;
  logic              frame_end;
  logic              alpha_full;
  logic              ratio_pass;
  logic              equal_rgb;
  logic              special_dim;
  logic              match_res;

  // Result register
  logic             out_vld_r,   out_vld_nxt;
  logic             out_match_r;
  logic             out_ident_r;
  logic [CNT_W-1:0] out_red_r;
  logic [CNT_W-1:0] out_green_r;
  logic [CNT_W-1:0] out_blue_r;
  logic [CNT_W-1:0] out_alpha_r;
  logic [CNT_W-1:0] out_visit_r;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [sim_pkg::CFG_W-1:0] v);
    logic [DIM_W-1:0] d;
    if (v == '0) begin
      d = DIM_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      d = DIM_W'(MAX_DIM);
    end else begin
      d = DIM_W'(v);
    end
    return d;
  endfunction

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + (CNT_W + 1)'(b);
    return s[CNT_W] ? sim_pkg::CNT_MAX : s[CNT_W-1:0];
  endfunction

  function automatic logic ratio_ok(input logic [CNT_W-1:0] c,
                                    input logic [CNT_W-1:0] v);
    return (RAT_W'(c) * RAT_W'(sim_pkg::MATCH_DEN)) >=
           (RAT_W'(v) * RAT_W'(sim_pkg::MATCH_NUM));
  endfunction

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r  <= sim_pkg::RST_IMAGE_WIDTH;
      height_cfg_r <= sim_pkg::RST_IMAGE_HEIGHT;
      tol_cfg_r    <= sim_pkg::RST_CHANNEL_TOL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sim_pkg::REG_IMAGE_WIDTH:  width_cfg_r  <= cfg_wdata;
        sim_pkg::REG_IMAGE_HEIGHT: height_cfg_r <= cfg_wdata;
        sim_pkg::REG_CHANNEL_TOL:  tol_cfg_r    <= cfg_wdata[sim_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  assign w_eff = eff_dim(width_cfg_r);
  assign h_eff = eff_dim(height_cfg_r);

  sim_off_div #(
    .SCAN_COUNT (SCAN_COUNT),
    .DIM_W      (DIM_W),
    .OFF_W      (OFF_W)
  ) u_col_div (
    .clk (clk),
    .dim (w_eff),
    .off (coff)
  );

  sim_off_div #(
    .SCAN_COUNT (SCAN_COUNT),
    .DIM_W      (DIM_W),
    .OFF_W      (OFF_W)
  ) u_row_div (
    .clk (clk),
    .dim (h_eff),
    .off (roff)
  );

  // Handshake: advance the held pair unless a result is still waiting
  assign adv       = pipe_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !pipe_vld_r || adv;
  assign in_xfer   = in_tvalid && in_tready;

  // Hold the incoming pair
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_vld_r <= 1'b0;
    end else if (in_tready) begin
      pipe_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pipe_src_r <= in_tdata[31:0];
      pipe_dst_r <= in_tdata[63:32];
    end
  end

  sim_pix_cmp u_cmp (
    .src_pixel (pipe_src_r),
    .dst_pixel (pipe_dst_r),
    .tolerance (tol_cfg_r),
    .flags     (flags)
  );

  // Sample, count and judge
  always_comb begin
    visits = 2'((roff != '0) && (row_phase_r == '0) && (row_pos_r != '0)) +
             2'((coff != '0) && (col_phase_r == '0) && (col_pos_r != '0));

    red_upd   = sat_add(red_cnt_r,   flags.red   ? visits : 2'd0);
    green_upd = sat_add(green_cnt_r, flags.green ? visits : 2'd0);
    blue_upd  = sat_add(blue_cnt_r,  flags.blue  ? visits : 2'd0);
    alpha_upd = sat_add(alpha_cnt_r, flags.alpha ? visits : 2'd0);
    visit_upd = sat_add(visit_cnt_r, visits);
    eq_upd    = all_equal_r && flags.equal;

    row_end   = DIM_W'(col_pos_r) >= (w_eff - DIM_W'(1));
    frame_end = row_end && (DIM_W'(row_pos_r) >= (h_eff - DIM_W'(1)));

    alpha_full  = (alpha_upd == visit_upd);
    ratio_pass  = ratio_ok(red_upd, visit_upd) && ratio_ok(green_upd, visit_upd) &&
                  ratio_ok(blue_upd, visit_upd) && alpha_full;
    equal_rgb   = (red_upd == green_upd) && (green_upd == blue_upd);
    special_dim = (w_eff == DIM_W'(sim_pkg::SPECIAL_DIM)) &&
                  (h_eff == DIM_W'(sim_pkg::SPECIAL_DIM));
    match_res   = eq_upd || ratio_pass || (equal_rgb && alpha_full && !special_dim);
  end

  // Next frame state
  always_comb begin
    col_pos_nxt   = col_pos_r;
    row_pos_nxt   = row_pos_r;
    col_phase_nxt = col_phase_r;
    row_phase_nxt = row_phase_r;
    red_cnt_nxt   = red_cnt_r;
    green_cnt_nxt = green_cnt_r;
    blue_cnt_nxt  = blue_cnt_r;
    alpha_cnt_nxt = alpha_cnt_r;
    visit_cnt_nxt = visit_cnt_r;
    all_equal_nxt = all_equal_r;
    if (adv) begin
      if (frame_end) begin
        col_pos_nxt   = '0;
        row_pos_nxt   = '0;
        col_phase_nxt = '0;
        row_phase_nxt = '0;
        red_cnt_nxt   = '0;
        green_cnt_nxt = '0;
        blue_cnt_nxt  = '0;
        alpha_cnt_nxt = '0;
        visit_cnt_nxt = '0;
        all_equal_nxt = 1'b1;
      end else begin
        red_cnt_nxt   = red_upd;
        green_cnt_nxt = green_upd;
        blue_cnt_nxt  = blue_upd;
        alpha_cnt_nxt = alpha_upd;
        visit_cnt_nxt = visit_upd;
        all_equal_nxt = eq_upd;
        if (row_end) begin
          col_pos_nxt   = '0;
          col_phase_nxt = '0;
          row_pos_nxt   = row_pos_r + POS_W'(1);
          if (roff == '0 || row_phase_r >= roff - OFF_W'(1)) begin
            row_phase_nxt = '0;
          end else begin
            row_phase_nxt = row_phase_r + OFF_W'(1);
          end
        end else begin
          col_pos_nxt = col_pos_r + POS_W'(1);
          if (coff == '0 || col_phase_r >= coff - OFF_W'(1)) begin
            col_phase_nxt = '0;
          end else begin
            col_phase_nxt = col_phase_r + OFF_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r   <= '0;
      row_pos_r   <= '0;
      col_phase_r <= '0;
      row_phase_r <= '0;
      red_cnt_r   <= '0;
      green_cnt_r <= '0;
      blue_cnt_r  <= '0;
      alpha_cnt_r <= '0;
      visit_cnt_r <= '0;
      all_equal_r <= 1'b1;
    end else begin
      col_pos_r   <= col_pos_nxt;
      row_pos_r   <= row_pos_nxt;
      col_phase_r <= col_phase_nxt;
      row_phase_r <= row_phase_nxt;
      red_cnt_r   <= red_cnt_nxt;
      green_cnt_r <= green_cnt_nxt;
      blue_cnt_r  <= blue_cnt_nxt;
      alpha_cnt_r <= alpha_cnt_nxt;
      visit_cnt_r <= visit_cnt_nxt;
      all_equal_r <= all_equal_nxt;
    end
  end

  // Load the result at frame end, drop it once transferred
  always_comb begin
    if (adv && frame_end) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && frame_end) begin
      out_match_r <= match_res;
      out_ident_r <= eq_upd;
      out_red_r   <= red_upd;
      out_green_r <= green_upd;
      out_blue_r  <= blue_upd;
      out_alpha_r <= alpha_upd;
      out_visit_r <= visit_upd;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, out_visit_r, out_alpha_r, out_blue_r, out_green_r,
                       out_red_r, out_ident_r, out_match_r};

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    red_cnt_r <= visit_cnt_r && green_cnt_r <= visit_cnt_r &&
    blue_cnt_r <= visit_cnt_r && alpha_cnt_r <= visit_cnt_r)
    else $error("channel count exceeds sampled count");

  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && frame_end) |=> (col_pos_r == '0 && row_pos_r == '0 &&
                            visit_cnt_r == '0 && all_equal_r))
    else $error("frame state not cleared after frame end");

  a_ident_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_ident_r) |-> (out_match_r && out_alpha_r == out_visit_r))
    else $error("identical frame reported without full match");

  a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (pipe_vld_r && !adv) |=> (pipe_vld_r && $stable(pipe_src_r) && $stable(pipe_dst_r)))
    else $error("held pixel pair lost while stalled");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import sim_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int LONG_HOLD   = 200;
  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic             images_match;
    logic             identical;
    logic [CNT_W-1:0] red_matches;
    logic [CNT_W-1:0] green_matches;
    logic [CNT_W-1:0] blue_matches;
    logic [CNT_W-1:0] alpha_matches;
    logic [CNT_W-1:0] sampled_count;
  } frame_result_t;

  // One directed frame: every pixel pair of the frame is the same
  typedef struct packed {
    logic             load;
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
    logic [CFG_W-1:0] tol_word;
    logic [PIX_W-1:0] src;
    logic [PIX_W-1:0] dst;
    logic             typed;
    frame_result_t    want;
  } frame_case_t;

  typedef enum int {PIX_SAME, PIX_NEAR, PIX_FAR, PIX_CLEAR, PIX_NOISE} pix_kind_t;

  localparam int N_CASES = 16;
  localparam frame_case_t FRAME_CASES [N_CASES] = '{
    // reset geometry 64 x 64: 12 scan rows and 12 scan columns of 64 pixels
    '{1'b0, 13'd64, 13'd64, 13'd32, 32'h1234_5678, 32'h1234_5678, 1'b1,
      '{1'b1, 1'b1, 20'd1536, 20'd1536, 20'd1536, 20'd1536, 20'd1536}},
    // single pixel frames, no scan lines
    '{1'b1, 13'd1, 13'd1, 13'd32, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      '{1'b1, 1'b1, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0}},
    '{1'b1, 13'd1, 13'd1, 13'd32, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
      '{1'b1, 1'b0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0}},
    // zero size is taken as one
    '{1'b1, 13'd0, 13'd0, 13'd32, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1,
      '{1'b1, 1'b0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0}},
    // one row of 12: columns 1..11 sampled
    '{1'b1, 13'd12, 13'd1, 13'd32, 32'h8080_8080, 32'h8080_8080, 1'b1,
      '{1'b1, 1'b1, 20'd11, 20'd11, 20'd11, 20'd11, 20'd11}},
    // zero tolerance: no color hits even on equal pixels
    '{1'b1, 13'd12, 13'd1, 13'd0, 32'h1122_3344, 32'h1122_3344, 1'b1,
      '{1'b1, 1'b1, 20'd0, 20'd0, 20'd0, 20'd11, 20'd11}},
    // tolerance zero by masking; equal color counts with full alpha still match
    '{1'b1, 13'd12, 13'd1, 13'h1E00, 32'h1122_3344, 32'h1122_3345, 1'b1,
      '{1'b1, 1'b0, 20'd0, 20'd0, 20'd0, 20'd11, 20'd11}},
    // tolerance 256: any color difference matches
    '{1'b1, 13'd12, 13'd1, 13'd256, 32'h1000_0000, 32'h10FF_FFFF, 1'b1,
      '{1'b1, 1'b0, 20'd11, 20'd11, 20'd11, 20'd11, 20'd11}},
    // transparent black against transparent white, both orders
    '{1'b1, 13'd12, 13'd1, 13'd32, 32'h0000_0000, 32'h00FF_FFFF, 1'b1,
      '{1'b1, 1'b0, 20'd11, 20'd11, 20'd11, 20'd11, 20'd11}},
    '{1'b1, 13'd12, 13'd1, 13'd32, 32'h00FF_FFFF, 32'h0000_0000, 1'b1,
      '{1'b1, 1'b0, 20'd11, 20'd11, 20'd11, 20'd11, 20'd11}},
    // almost the transparent pair: nothing matches, alpha short
    '{1'b1, 13'd12, 13'd1, 13'd32, 32'h0100_0000, 32'h00FF_FFFF, 1'b1,
      '{1'b0, 1'b0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd11}},
    // red at tolerance minus one, green at tolerance
    '{1'b1, 13'd12, 13'd1, 13'd32, 32'hFF10_2030, 32'hFF2F_0030, 1'b1,
      '{1'b0, 1'b0, 20'd11, 20'd0, 20'd11, 20'd11, 20'd11}},
    // all-ones tolerance word
    '{1'b1, 13'd12, 13'd1, 13'h1FFF, 32'h7F00_FF00, 32'h7FFF_00FF, 1'b1,
      '{1'b1, 1'b0, 20'd11, 20'd11, 20'd11, 20'd11, 20'd11}},
    // 27 x 27 is excluded from the equal-count fallback
    '{1'b1, 13'd27, 13'd27, 13'd32, 32'h4000_0000, 32'h4080_8080, 1'b1,
      '{1'b0, 1'b0, 20'd0, 20'd0, 20'd0, 20'd702, 20'd702}},
    // scan row and column crossings
    '{1'b1, 13'd13, 13'd12, 13'd8, 32'h4010_2030, 32'h4113_2231, 1'b0, '0},
    // one column of 12: rows 1..11 sampled
    '{1'b1, 13'd1, 13'd12, 13'd32, 32'h0102_0304, 32'h0102_0304, 1'b1,
      '{1'b1, 1'b1, 20'd11, 20'd11, 20'd11, 20'd11, 20'd11}}
  };

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]   cfg_wdata;
  logic               in_tvalid;
  logic               in_tready;
  logic [63:0]        in_tdata;    // src_pixel[31:0], dst_pixel[63:32]
  logic               out_tvalid;
  logic               out_tready;
  // images_match[0], identical[1], red_matches[21:2], green_matches[41:22],
  // blue_matches[61:42], alpha_matches[81:62], sampled_count[101:82], zero pad
  logic [103:0]       out_tdata;

  // Predictor state and configuration
  logic [CFG_W-1:0]   model_width;
  logic [CFG_W-1:0]   model_height;
  logic [TOL_W-1:0]   model_tol;
  int unsigned        x_pos, y_pos, x_phase, y_phase;
  logic [CNT_W-1:0]   red_hits, green_hits, blue_hits, alpha_hits, sample_hits;
  bit                 frame_same;

  frame_result_t      frame_reports_due [$];
  int                 fail_count = 0;
  int unsigned        cycle_count = 0;

  // Stimulus shaping
  bit                 quiet = 1'b0;
  bit                 steady = 1'b0;
  bit                 hold_req = 1'b0;
  pix_kind_t          frame_kind = PIX_SAME;
  int unsigned        near_span, outlier_pct, alpha_err_pct;
  int unsigned        big_left = 3;
  int unsigned        items_sent = 0;
  int unsigned        frames_sent = 0;

  scanline_image_match i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned eff_dim(logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_DIM_DEF) return MAX_DIM_DEF;
    return int'(v);
  endfunction

  function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] c, int unsigned v);
    int unsigned sum;
    sum = int'(c) + v;
    return (sum > int'(CNT_MAX)) ? CNT_MAX : CNT_W'(sum);
  endfunction

  function automatic bit chan_close(logic [7:0] a, logic [7:0] b);
    int unsigned diff;
    diff = (a > b) ? int'(a - b) : int'(b - a);
    return diff < int'(model_tol);
  endfunction

  function automatic bit ratio_ok(logic [CNT_W-1:0] c);
    return longint'(c) * MATCH_DEN >= longint'(sample_hits) * MATCH_NUM;
  endfunction

  function automatic void clear_frame();
    x_pos = 0;
    y_pos = 0;
    x_phase = 0;
    y_phase = 0;
    red_hits = '0;
    green_hits = '0;
    blue_hits = '0;
    alpha_hits = '0;
    sample_hits = '0;
    frame_same = 1'b1;
  endfunction

  // Advance the frame by one pixel pair; report the frame result on its last pair
  task automatic score_pixel_pair(input logic [PIX_W-1:0] s, input logic [PIX_W-1:0] d,
                                  output bit done, output frame_result_t r);
    int unsigned w, h, col_gap, row_gap, visits;
    bit clear_pair, row_end, alpha_full, ok;
    w = eff_dim(model_width);
    h = eff_dim(model_height);
    col_gap = w / (2 * SCAN_COUNT_DEF);
    row_gap = h / (2 * SCAN_COUNT_DEF);
    visits = 0;
    done = 1'b0;
    r = '0;
    if (s != d) frame_same = 1'b0;
    if (row_gap != 0 && y_phase == 0 && y_pos != 0) visits++;
    if (col_gap != 0 && x_phase == 0 && x_pos != 0) visits++;

    // count channel hits on scan lines
    if (visits != 0) begin
      clear_pair = (s == '0 && d == CLEAR_WHITE) || (d == '0 && s == CLEAR_WHITE);
      if (clear_pair || chan_close(s[23:16], d[23:16])) red_hits = sat_add(red_hits, visits);
      if (clear_pair || chan_close(s[15:8], d[15:8])) green_hits = sat_add(green_hits, visits);
      if (clear_pair || chan_close(s[7:0], d[7:0])) blue_hits = sat_add(blue_hits, visits);
      if (clear_pair || s[31:24] == d[31:24]) alpha_hits = sat_add(alpha_hits, visits);
      sample_hits = sat_add(sample_hits, visits);
    end

    row_end = x_pos >= w - 1;
    if (row_end && y_pos >= h - 1) begin
      // frame verdict
      alpha_full = alpha_hits == sample_hits;
      ok = frame_same;
      if (!ok) begin
        ok = ratio_ok(red_hits) && ratio_ok(green_hits) && ratio_ok(blue_hits) && alpha_full;
        if (!ok && red_hits == green_hits && green_hits == blue_hits && alpha_full &&
            !(w == SPECIAL_DIM && h == SPECIAL_DIM))
          ok = 1'b1;
      end
      r = '{ok, frame_same, red_hits, green_hits, blue_hits, alpha_hits, sample_hits};
      done = 1'b1;
      clear_frame();
    end else if (row_end) begin
      x_pos = 0;
      x_phase = 0;
      y_pos++;
      y_phase = (row_gap == 0 || y_phase >= row_gap - 1) ? 0 : y_phase + 1;
    end else begin
      x_pos++;
      x_phase = (col_gap == 0 || x_phase >= col_gap - 1) ? 0 : x_phase + 1;
    end
  endtask

  // ---------------------------------------------------------------- drivers

  task automatic send_pair(input logic [PIX_W-1:0] s, input logic [PIX_W-1:0] d,
                           input bit typed, input frame_result_t want);
    int unsigned gap;
    bit done;
    frame_result_t r;
    gap = 0;
    if (!quiet && !steady && $urandom_range(0, 11) == 0) gap = $urandom_range(1, 16);
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {d, s};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    score_pixel_pair(s, d, done, r);
    if (done) frame_reports_due.push_back(typed ? want : r);
  endtask

  task automatic go_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (frame_reports_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all registers, now and then the unused index too; block must be idle
  task automatic load_regs(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                           input logic [CFG_W-1:0] tw);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_wdata <= h;
    @(negedge clk);
    cfg_index <= REG_CHANNEL_TOL;
    cfg_wdata <= tw;
    if ($urandom_range(0, 4) == 0) begin
      @(negedge clk);
      cfg_index <= REG_SPARE;
      cfg_wdata <= CFG_W'($urandom);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    model_width  = w;
    model_height = h;
    model_tol    = tw[TOL_W-1:0];
    // let the scan spacing settle
    repeat (2) @(negedge clk);
  endtask

  function automatic logic [7:0] nudge(logic [7:0] c);
    int v;
    v = int'(c);
    if ($urandom_range(0, 1) != 0) v = v + int'($urandom_range(0, near_span));
    else v = v - int'($urandom_range(0, near_span));
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  task automatic gen_pair(output logic [PIX_W-1:0] s, output logic [PIX_W-1:0] d);
    int unsigned k;
    s = $urandom;
    case (frame_kind)
      PIX_SAME: d = s;
      PIX_NEAR: begin
        d = {s[31:24], nudge(s[23:16]), nudge(s[15:8]), nudge(s[7:0])};
        if ($urandom_range(0, 99) < outlier_pct) begin
          k = $urandom_range(0, 2);
          d[8*k +: 8] = d[8*k +: 8] ^ 8'h80;
        end
        if ($urandom_range(0, 99) < alpha_err_pct)
          d[31:24] = s[31:24] ^ 8'($urandom_range(1, 255));
      end
      PIX_FAR: d = {s[31:24], s[23:0] ^ 24'h80_8080};
      PIX_CLEAR: begin
        if ($urandom_range(0, 1) != 0) begin
          s = ($urandom_range(0, 1) != 0) ? CLEAR_WHITE : '0;
          d = (s == '0) ? CLEAR_WHITE : '0;
        end else begin
          d = s;
        end
      end
      default: d = $urandom;
    endcase
  endtask

  task automatic pick_config(output logic [CFG_W-1:0] w, output logic [CFG_W-1:0] h,
                             output logic [CFG_W-1:0] tw);
    int unsigned sel;
    logic [CFG_W-1:0] t;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      w = CFG_W'($urandom_range(0, 13));
      h = CFG_W'($urandom_range(0, 13));
    end else if (sel < 75) begin
      w = CFG_W'($urandom_range(12, 30));
      h = CFG_W'($urandom_range(1, 30));
    end else if (sel < 85) begin
      w = 13'd27;
      h = ($urandom_range(0, 1) != 0) ? 13'd27 : CFG_W'($urandom_range(25, 29));
    end else if (sel < 92 && big_left != 0) begin
      big_left--;
      w = CFG_W'($urandom_range(3000, 8191));
      h = CFG_W'($urandom_range(0, 1));
    end else begin
      w = CFG_W'($urandom_range(31, 200));
      h = CFG_W'($urandom_range(1, 6));
    end
    if ($urandom_range(0, 1) != 0) begin
      t = w;
      w = h;
      h = t;
    end
    sel = $urandom_range(0, 99);
    if (sel < 10) t = 13'd0;
    else if (sel < 20) t = CFG_W'($urandom_range(256, 511));
    else if (sel < 30) t = 13'd1;
    else if (sel < 40) t = 13'd255;
    else t = CFG_W'($urandom_range(2, 64));
    tw = {4'($urandom), t[TOL_W-1:0]};
  endtask

  // Reconfigure once idle, then stream whole frames of random content
  task automatic run_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                           input logic [CFG_W-1:0] tw);
    int unsigned frames, area, sel, tol;
    logic [PIX_W-1:0] s, d;
    go_idle();
    wait_drained();
    load_regs(w, h, tw);
    area = eff_dim(w) * eff_dim(h);
    frames = (area <= 400) ? $urandom_range(1, 4) : 1;
    tol = int'(tw[TOL_W-1:0]);
    repeat (frames) begin
      sel = $urandom_range(0, 9);
      if (sel < 2) frame_kind = PIX_SAME;
      else if (sel < 7) frame_kind = PIX_NEAR;
      else if (sel == 7) frame_kind = PIX_FAR;
      else if (sel == 8) frame_kind = PIX_CLEAR;
      else frame_kind = PIX_NOISE;
      sel = $urandom_range(0, 3);
      if (sel == 0) near_span = (tol == 0) ? 0 : tol - 1;
      else if (sel == 1) near_span = tol + 4;
      else if (sel == 2) near_span = 3;
      else near_span = 255;
      if (near_span > 255) near_span = 255;
      outlier_pct = $urandom_range(0, 8);
      alpha_err_pct = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
      steady = ($urandom_range(0, 3) == 0);
      repeat (area) begin
        gen_pair(s, d);
        send_pair(s, d, 1'b0, '0);
      end
      items_sent += area;
      frames_sent++;
    end
  endtask

  // ---------------------------------------------------------------- result side

  // Hold off in random bursts, or for one long stretch on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        out_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Compare each result transfer with the oldest expected frame report
  always @(posedge clk) begin
    frame_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[0], out_tdata[1], out_tdata[21:2], out_tdata[41:22],
              out_tdata[61:42], out_tdata[81:62], out_tdata[101:82]};
      if (frame_reports_due.size() == 0) begin
        $error("frame result transfer with none expected");
        fail_count++;
      end else begin
        want = frame_reports_due.pop_front();
        check_field("images_match", want.images_match, got.images_match);
        check_field("identical", want.identical, got.identical);
        check_field("red_matches", want.red_matches, got.red_matches);
        check_field("green_matches", want.green_matches, got.green_matches);
        check_field("blue_matches", want.blue_matches, got.blue_matches);
        check_field("alpha_matches", want.alpha_matches, got.alpha_matches);
        check_field("sampled_count", want.sampled_count, got.sampled_count);
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    frame_case_t fc;
    int unsigned total;
    logic [CFG_W-1:0] w, h, tw;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    model_width  = RST_IMAGE_WIDTH;
    model_height = RST_IMAGE_HEIGHT;
    model_tol    = RST_CHANNEL_TOL;
    clear_frame();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed frames
    for (int k = 0; k < N_CASES; k++) begin
      fc = FRAME_CASES[k];
      if (fc.load) begin
        go_idle();
        wait_drained();
        load_regs(fc.width, fc.height, fc.tol_word);
      end
      total = eff_dim(model_width) * eff_dim(model_height);
      repeat (total) send_pair(fc.src, fc.dst, fc.typed, fc.want);
    end

    // single-pixel frames against a long receiver hold: the block must stall input
    go_idle();
    wait_drained();
    load_regs(13'd1, 13'd1, 13'd32);
    @(posedge clk);
    hold_req = 1'b1;
    steady = 1'b1;
    repeat (40) send_pair($urandom, $urandom, 1'b0, '0);

    // size extremes, then random geometry and content
    run_phase(13'h1FFF, 13'd0, 13'h1FFF);
    run_phase(13'd1, 13'd4097, 13'd0);
    items_sent = 0;
    frames_sent = 0;
    while (items_sent < 900 || frames_sent < 60) begin
      pick_config(w, h, tw);
      run_phase(w, h, tw);
    end

    // closing stretch with no random idling on either side
    go_idle();
    wait_drained();
    quiet = 1'b1;
    repeat (3) begin
      pick_config(w, h, tw);
      run_phase(w, h, tw);
    end
    go_idle();
    wait_drained();
    repeat (8) @(posedge clk);

    if (fail_count == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule
